>>> rtl/core/kos_pkg.sv
// keyed overlay scroll buffer: shared types, constants and helper functions
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kos_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int AW   = XW + YW;
    localparam int DIMW = 7;
    localparam int NW   = (XW > YW) ? XW : YW;
    localparam int CW   = 24;
    localparam int EW   = CW + 1;

    localparam logic [2:0] OP_DRAW  = 3'd0;
    localparam logic [2:0] OP_ERASE = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_SHIFT = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_BG     = 2'd3;

    typedef enum logic [2:0] {
        CK_WRITE,
        CK_READ,
        CK_CLEAR,
        CK_SHIFT,
        CK_REPLY
    } kind_t;

    typedef struct packed {
        kind_t          kind;
        logic [AW-1:0]  addr;
        logic [EW-1:0]  wdata;
        logic           status;
        logic [NW-1:0]  amount;
        logic [1:0]     dir;
    } cmd_t;

    function automatic logic [CW-1:0] frame_order(input logic fmt, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b);
        frame_order = fmt ? {r, g, b} : {b, g, r};
    endfunction

    function automatic logic [DIMW-1:0] clamp_dim(input logic [DIMW-1:0] v,
                                                  input logic [DIMW-1:0] lim);
        clamp_dim = (v > lim) ? lim : v;
    endfunction

endpackage

>>> rtl/core/keyed_overlay_scroll_buffer_core.sv
// keyed overlay scroll buffer: top level with configuration registers
// depends on kos_pkg, kos_front, kos_back
`timescale 1ns / 1ps

// usage:
//  requests enter on in_valid/in_stall, one result per request leaves on
//  out_valid/out_stall; configuration goes through cfg_valid/cfg_ready with
//  cfg_index selecting format, width, height or background color
//  draw, erase and rejected or unused requests: result registered in the cycle
//  after the command leaves the queue; read: the registered store port, then
//  S_READ, then the result register; clear and shift: one sweep over all 4096
//  entries, each zeroed entry written once, each moved entry read in S_SWRD
//  and then written to its destination in S_SWWR
//  a two-entry queue lets requests enter while the store is busy
//  after reset the store is cleared in a pass over all 4096 entries; in_stall
//  is high during it, configuration writes are taken
//  while out_stall is high the result holds and the queue fills, then
//  in_stall rises

module keyed_overlay_scroll_buffer_core
    import kos_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      op,
    input  logic [5:0]      x,
    input  logic [5:0]      y,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic [11:0]     shift_amount,
    input  logic [1:0]      direction,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            status,
    output logic [23:0]     pixel_value,
    output logic            from_overlay,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [23:0]     cfg_data
);

    logic            fmt_reg;
    logic [DIMW-1:0] width_reg;
    logic [DIMW-1:0] height_reg;
    logic [CW-1:0]   bg_reg;
    logic [DIMW-1:0] act_w, act_h;
    logic            q_valid, q_pop, init_busy;
    cmd_t            q_cmd;

    assign cfg_ready = 1'b1;
    assign act_w = clamp_dim(width_reg, DIMW'(MAX_WIDTH));
    assign act_h = clamp_dim(height_reg, DIMW'(MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= 1'b0;
            width_reg  <= DIMW'(64);
            height_reg <= DIMW'(64);
            bg_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FORMAT: fmt_reg    <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= cfg_data[DIMW-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIMW-1:0];
                default:    bg_reg     <= cfg_data;
            endcase
        end
    end

    kos_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .x            (x),
        .y            (y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .shift_amount (shift_amount),
        .direction    (direction),
        .fmt          (fmt_reg),
        .act_w        (act_w),
        .act_h        (act_h),
        .init_busy    (init_busy),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    kos_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .init_busy    (init_busy),
        .fmt          (fmt_reg),
        .act_w        (act_w),
        .act_h        (act_h),
        .bg           (bg_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .pixel_value  (pixel_value),
        .from_overlay (from_overlay)
    );

endmodule

>>> rtl/core/kos_front.sv
// keyed overlay scroll buffer: request decode and two-entry command queue
// depends on kos_pkg
`timescale 1ns / 1ps

module kos_front
    import kos_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      op,
    input  logic [5:0]      x,
    input  logic [5:0]      y,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic [11:0]     shift_amount,
    input  logic [1:0]      direction,
    input  logic            fmt,
    input  logic [DIMW-1:0] act_w,
    input  logic [DIMW-1:0] act_h,
    input  logic            init_busy,
    output logic            q_valid,
    output cmd_t            q_cmd,
    input  logic            q_pop
);

    cmd_t           cmd;
    logic           in_range;
    logic [DIMW-1:0] dim;
    cmd_t           q_mem [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign in_range = ({1'b0, x} < act_w) && ({1'b0, y} < act_h);
    assign dim      = direction[1] ? act_w : act_h;

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = CK_REPLY;
        cmd.addr   = {y, x};
        cmd.amount = shift_amount[NW-1:0];
        cmd.dir    = direction;
        unique case (op)
            OP_DRAW:
            begin
                if (in_range)
                begin
                    cmd.kind  = CK_WRITE;
                    cmd.wdata = {1'b1, frame_order(fmt, red, green, blue)};
                end
                else
                begin
                    cmd.status = 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (in_range)
                begin
                    cmd.kind = CK_WRITE;
                end
                else
                begin
                    cmd.status = 1'b1;
                end
            end
            OP_READ:
            begin
                if (in_range)
                begin
                    cmd.kind = CK_READ;
                end
                else
                begin
                    cmd.status = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                cmd.kind = CK_CLEAR;
            end
            OP_SHIFT:
            begin
                if (shift_amount == '0)
                begin
                    cmd.kind = CK_REPLY;
                end
                else if (shift_amount >= {{(12-DIMW){1'b0}}, dim})
                begin
                    cmd.kind = CK_CLEAR;
                end
                else
                begin
                    cmd.kind = CK_SHIFT;
                end
            end
            default:
            begin
                cmd.kind = CK_REPLY;
            end
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2) || init_busy;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ q_pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> rtl/core/kos_back.sv
// keyed overlay scroll buffer: pixel store, sweep engine and result register
// depends on kos_pkg
`timescale 1ns / 1ps

module kos_back
    import kos_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cmd_t            q_cmd,
    output logic            q_pop,
    output logic            init_busy,
    input  logic            fmt,
    input  logic [DIMW-1:0] act_w,
    input  logic [DIMW-1:0] act_h,
    input  logic [CW-1:0]   bg,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            status,
    output logic [CW-1:0]   pixel_value,
    output logic            from_overlay
);

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_SWRD = 5'b00100,
        S_SWWR = 5'b01000,
        S_READ = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            desc_reg, desc_next;
    logic            clr_reg, clr_next;
    logic [NW-1:0]   amt_reg, amt_next;
    logic [1:0]      dir_reg, dir_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_status_reg, out_status_next;
    logic [CW-1:0]   out_pix_reg, out_pix_next;
    logic            out_ovl_reg, out_ovl_next;

    logic [EW-1:0]   mem [MAX_WIDTH*MAX_HEIGHT];
    logic [EW-1:0]   rd_data_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [EW-1:0]   wdata;
    logic [AW-1:0]   raddr;

    logic            out_free;
    logic [AW-1:0]   dst;
    logic [XW-1:0]   dx, sx;
    logic [YW-1:0]   dy, sy;
    logic [DIMW-1:0] sum_x, sum_y;
    logic            dir_ok, in_act, src_ok, sweep_last;
    logic [CW-1:0]   bg_frame;

    assign out_free   = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == S_IDLE) && q_valid && out_free;
    assign init_busy  = (state_reg == S_INIT);
    assign dst        = desc_reg ? ~cnt_reg : cnt_reg;
    assign dx         = dst[XW-1:0];
    assign dy         = dst[AW-1:XW];
    assign sweep_last = (cnt_reg == {AW{1'b1}});
    assign sum_x      = DIMW'(dx) + DIMW'(amt_reg);
    assign sum_y      = DIMW'(dy) + DIMW'(amt_reg);
    assign in_act     = ({1'b0, dx} < act_w) && ({1'b0, dy} < act_h);
    assign bg_frame   = frame_order(fmt, bg[23:16], bg[15:8], bg[7:0]);

    always_comb
    begin
        sx     = dx;
        sy     = dy;
        dir_ok = 1'b0;
        unique case (dir_reg)
            DIR_UP:
            begin
                sy     = sum_y[YW-1:0];
                dir_ok = sum_y < act_h;
            end
            DIR_DOWN:
            begin
                sy     = dy - YW'(amt_reg);
                dir_ok = NW'(dy) >= amt_reg;
            end
            DIR_LEFT:
            begin
                sx     = sum_x[XW-1:0];
                dir_ok = sum_x < act_w;
            end
            default:
            begin
                sx     = dx - XW'(amt_reg);
                dir_ok = NW'(dx) >= amt_reg;
            end
        endcase
    end

    assign src_ok = !clr_reg && in_act && dir_ok;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        desc_next       = desc_reg;
        clr_next        = clr_reg;
        amt_next        = amt_reg;
        dir_next        = dir_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_pix_next    = out_pix_reg;
        out_ovl_next    = out_ovl_reg;
        we              = 1'b0;
        waddr           = dst;
        wdata           = '0;
        raddr           = {sy, sx};
        unique case (state_reg)
            S_INIT:
            begin
                we       = 1'b1;
                waddr    = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                raddr = q_cmd.addr;
                if (q_pop)
                begin
                    case (q_cmd.kind)
                        CK_WRITE:
                        begin
                            we              = 1'b1;
                            waddr           = q_cmd.addr;
                            wdata           = q_cmd.wdata;
                            out_valid_next  = 1'b1;
                            out_status_next = 1'b0;
                            out_pix_next    = '0;
                            out_ovl_next    = 1'b0;
                        end
                        CK_READ:
                        begin
                            state_next = S_READ;
                        end
                        CK_CLEAR:
                        begin
                            clr_next   = 1'b1;
                            desc_next  = 1'b0;
                            cnt_next   = '0;
                            state_next = S_SWRD;
                        end
                        CK_SHIFT:
                        begin
                            clr_next   = 1'b0;
                            desc_next  = (q_cmd.dir == DIR_DOWN) || (q_cmd.dir == DIR_RIGHT);
                            amt_next   = q_cmd.amount;
                            dir_next   = q_cmd.dir;
                            cnt_next   = '0;
                            state_next = S_SWRD;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = q_cmd.status;
                            out_pix_next    = '0;
                            out_ovl_next    = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next  = 1'b1;
                out_status_next = 1'b0;
                out_ovl_next    = rd_data_reg[CW];
                out_pix_next    = rd_data_reg[CW] ? rd_data_reg[CW-1:0] : bg_frame;
                state_next      = S_IDLE;
            end
            S_SWRD:
            begin
                if (src_ok)
                begin
                    state_next = S_SWWR;
                end
                else
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (sweep_last)
                    begin
                        state_next      = S_IDLE;
                        out_valid_next  = 1'b1;
                        out_status_next = 1'b0;
                        out_pix_next    = '0;
                        out_ovl_next    = 1'b0;
                    end
                end
            end
            S_SWWR:
            begin
                we       = 1'b1;
                wdata    = rd_data_reg;
                cnt_next = cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_pix_next    = '0;
                    out_ovl_next    = 1'b0;
                end
                else
                begin
                    state_next = S_SWRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_pix_reg    <= out_pix_next;
        out_ovl_reg    <= out_ovl_next;
        desc_reg       <= desc_next;
        clr_reg        <= clr_next;
        amt_reg        <= amt_next;
        dir_reg        <= dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign pixel_value  = out_pix_reg;
    assign from_overlay = out_ovl_reg;

`ifndef NO_ASSERTIONS
    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !we)
        else $error("store written while read data pending");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid_reg || !out_stall))
        else $error("command taken with result register full");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWWR) |-> $past(state_reg == S_SWRD))
        else $error("sweep write without preceding read");
`endif

endmodule

>>> tb/sv/tb_keyed_overlay_scroll_buffer_core.sv
// testbench for keyed_overlay_scroll_buffer_core: drives draw, erase, clear, shift and
// read requests, predicts each result from a local overlay store model and compares
// depends on kos_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_keyed_overlay_scroll_buffer_core
    import kos_pkg::*;
();

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] amount;
        logic [1:0]  dir;
    } pix_req_t;

    typedef struct packed {
        logic        status;
        logic [23:0] value;
        logic        overlay;
    } pix_res_t;

    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] shift_amount;
    logic [1:0]  direction;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [23:0] pixel_value;
    logic        from_overlay;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    keyed_overlay_scroll_buffer_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .x(x), .y(y), .red(red), .green(green), .blue(blue),
        .shift_amount(shift_amount), .direction(direction),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .pixel_value(pixel_value), .from_overlay(from_overlay),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // overlay model state
    logic [24:0] overlay_mem [MAX_WIDTH*MAX_HEIGHT] = '{default: '0};
    logic        fmt_reg;
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [23:0] bg_reg;

    pix_req_t pending_reqs[$];
    pix_res_t expected_pixels[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       mismatches = 0;
    int       cycles = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [23:0] to_frame(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        if (fmt_reg)
            return {r, g, b};
        return {b, g, r};
    endfunction

    function automatic int act_w();
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int act_h();
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    task automatic wipe_overlay();
        for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++)
            overlay_mem[i] = '0;
    endtask

    task automatic scroll_overlay(input int n, input logic [1:0] d);
        int w;
        int h;
        w = act_w();
        h = act_h();
        if (n == 0)
            return;
        if (((d == DIR_UP || d == DIR_DOWN) && n >= h) ||
            ((d == DIR_LEFT || d == DIR_RIGHT) && n >= w))
        begin
            wipe_overlay();
            return;
        end
        for (int r = 0; r < MAX_HEIGHT; r++)
            for (int c = 0; c < MAX_WIDTH; c++)
                if (c >= w || r >= h)
                    overlay_mem[r*MAX_WIDTH+c] = '0;
        case (d)
            DIR_UP:
                for (int r = 0; r < h; r++)
                    for (int c = 0; c < w; c++)
                        overlay_mem[r*MAX_WIDTH+c] =
                            (r + n < h) ? overlay_mem[(r+n)*MAX_WIDTH+c] : '0;
            DIR_DOWN:
                for (int r = h - 1; r >= 0; r--)
                    for (int c = 0; c < w; c++)
                        overlay_mem[r*MAX_WIDTH+c] =
                            (r >= n) ? overlay_mem[(r-n)*MAX_WIDTH+c] : '0;
            DIR_LEFT:
                for (int r = 0; r < h; r++)
                    for (int c = 0; c < w; c++)
                        overlay_mem[r*MAX_WIDTH+c] =
                            (c + n < w) ? overlay_mem[r*MAX_WIDTH+c+n] : '0;
            default:
                for (int r = 0; r < h; r++)
                    for (int c = w - 1; c >= 0; c--)
                        overlay_mem[r*MAX_WIDTH+c] =
                            (c >= n) ? overlay_mem[r*MAX_WIDTH+c-n] : '0;
        endcase
    endtask

    // applies one accepted request to the model and queues its result
    task automatic predict_pixel(input pix_req_t q);
        pix_res_t res;
        logic     in_range;
        int       idx;
        res = '0;
        in_range = (q.x < act_w()) && (q.y < act_h());
        idx = q.y * MAX_WIDTH + q.x;
        if (q.op == OP_DRAW || q.op == OP_ERASE || q.op == OP_READ)
        begin
            if (!in_range)
                res.status = 1'b1;
            else if (q.op == OP_DRAW)
                overlay_mem[idx] = {1'b1, to_frame(q.red, q.green, q.blue)};
            else if (q.op == OP_ERASE)
                overlay_mem[idx] = '0;
            else if (overlay_mem[idx][24])
            begin
                res.value = overlay_mem[idx][23:0];
                res.overlay = 1'b1;
            end
            else
                res.value = to_frame(bg_reg[23:16], bg_reg[15:8], bg_reg[7:0]);
        end
        else if (q.op == OP_CLEAR)
            wipe_overlay();
        else if (q.op == OP_SHIFT)
            scroll_overlay(int'(q.amount), q.dir);
        expected_pixels.push_back(res);
    endtask

    function automatic pix_req_t make_req(input logic [2:0] o, input int cx, input int cy);
        pix_req_t q;
        q.op = o;
        q.x = (cx > 63) ? 6'd63 : 6'(cx);
        q.y = (cy > 63) ? 6'd63 : 6'(cy);
        q.red = 8'($urandom);
        q.green = 8'($urandom);
        q.blue = 8'($urandom);
        q.amount = 12'($urandom);
        q.dir = 2'($urandom);
        return q;
    endfunction

    function automatic pix_req_t rand_req();
        pix_req_t q;
        int       pick;
        int       w;
        int       h;
        w = act_w();
        h = act_h();
        pick = $urandom_range(0, 99);
        if (pick < 35)
            q = make_req(OP_DRAW, $urandom_range(0, w), $urandom_range(0, h));
        else if (pick < 45)
            q = make_req(OP_ERASE, $urandom_range(0, w), $urandom_range(0, h));
        else if (pick < 80)
            q = make_req(OP_READ, $urandom_range(0, w), $urandom_range(0, h));
        else if (pick < 88)
        begin
            q = make_req(OP_SHIFT, 0, 0);
            if ($urandom_range(0, 3) != 0)
                q.amount = 12'($urandom_range(0, 8));
        end
        else if (pick < 90)
            q = make_req(OP_CLEAR, $urandom, $urandom);
        else if (pick < 94)
            q = make_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom, $urandom);
        else
            q = make_req(OP_READ, $urandom, $urandom);
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (10000) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_FORMAT: fmt_reg = val[0];
            CFG_WIDTH:  width_reg = val[6:0];
            CFG_HEIGHT: height_reg = val[6:0];
            default:    bg_reg = val;
        endcase
    endtask

    task automatic run_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
            pending_reqs.push_back(rand_req());
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {op, x, y, red, green, blue, shift_amount, direction} <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                pix_req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                {op, x, y, red, green, blue, shift_amount, direction} <= q;
                predict_pixel(q);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                pix_res_t want;
                if (expected_pixels.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d value=%06h overlay=%0d",
                                 status, pixel_value, from_overlay);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.status !== status || want.value !== pixel_value ||
                        want.overlay !== from_overlay)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%06h/%0d got %0d/%06h/%0d",
                                     want.status, want.value, want.overlay,
                                     status, pixel_value, from_overlay);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
        else
            out_stall <= 1'b0;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        pix_req_t q;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FORMAT;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fmt_reg = 1'b0;
        width_reg = 7'd64;
        height_reg = 7'd64;
        bg_reg = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_BG, 24'h123456);
        // directed: corners, white, format change, shifts, unused ops
        q = make_req(OP_DRAW, 0, 0);
        q.red = 8'hFF; q.green = 8'hFF; q.blue = 8'hFF;
        pending_reqs.push_back(q);
        q = make_req(OP_DRAW, 63, 63);
        q.red = 8'h00; q.green = 8'h00; q.blue = 8'h00;
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(OP_DRAW, 5, 7));
        pending_reqs.push_back(make_req(OP_READ, 0, 0));
        pending_reqs.push_back(make_req(OP_READ, 63, 63));
        pending_reqs.push_back(make_req(OP_READ, 1, 1));
        pending_reqs.push_back(make_req(OP_ERASE, 63, 63));
        pending_reqs.push_back(make_req(OP_READ, 63, 63));
        q = make_req(OP_SHIFT, 0, 0); q.amount = 12'd0; q.dir = DIR_UP;
        pending_reqs.push_back(q);
        for (int d = 0; d < 4; d++)
        begin
            q = make_req(OP_SHIFT, 0, 0); q.amount = 12'd3; q.dir = 2'(d);
            pending_reqs.push_back(q);
            pending_reqs.push_back(make_req(OP_READ, 5, 7));
        end
        q = make_req(OP_READ, 2, 2); pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(OP_SPARE_LO, 1, 1));
        pending_reqs.push_back(make_req(OP_SPARE_HI, 63, 0));
        wait_drained();

        write_reg(CFG_FORMAT, 24'd1);
        write_reg(CFG_WIDTH, 24'd10);
        write_reg(CFG_HEIGHT, 24'd1);
        pending_reqs.push_back(make_req(OP_READ, 5, 7));
        pending_reqs.push_back(make_req(OP_DRAW, 9, 0));
        pending_reqs.push_back(make_req(OP_ERASE, 10, 0));
        pending_reqs.push_back(make_req(OP_READ, 9, 0));
        q = make_req(OP_SHIFT, 0, 0); q.amount = 12'd4095; q.dir = DIR_DOWN;
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(OP_READ, 9, 0));
        pending_reqs.push_back(make_req(OP_CLEAR, 0, 0));
        wait_drained();

        write_reg(CFG_WIDTH, 24'd0);
        write_reg(CFG_HEIGHT, 24'd127);
        pending_reqs.push_back(make_req(OP_DRAW, 0, 0));
        pending_reqs.push_back(make_req(OP_READ, 0, 0));
        wait_drained();

        write_reg(CFG_WIDTH, 24'd16);
        write_reg(CFG_HEIGHT, 24'd12);
        write_reg(CFG_BG, 24'hFFFFFF);
        run_random(250, 37, 58);
        wait_drained();

        write_reg(CFG_FORMAT, 24'd0);
        write_reg(CFG_WIDTH, 24'd64);
        write_reg(CFG_HEIGHT, 24'd64);
        write_reg(CFG_BG, 24'($urandom));
        run_random(250, 58, 37);
        wait_drained();

        write_reg(CFG_WIDTH, 24'd7);
        write_reg(CFG_HEIGHT, 24'd33);
        write_reg(CFG_BG, 24'h000000);
        run_random(250, 0, 0);
        wait_drained();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
